// ----- sv/ihex_pkg.sv -----
`default_nettype none

package ihex_pkg;

	localparam int MAX_DATA_BYTES = 32;
	localparam int LINE_DEPTH     = MAX_DATA_BYTES + 5;
	localparam int ADDR_W         = $clog2(LINE_DEPTH);
	localparam int IDX_W          = $clog2(MAX_DATA_BYTES + 1);
	localparam int CHAR_W         = 9;
	localparam int HARD_MAX_CHARS = 266;
	localparam int LIMIT_CHARS    = (2 * LINE_DEPTH < HARD_MAX_CHARS) ?
		2 * LINE_DEPTH : HARD_MAX_CHARS;
	localparam int MIN_CHARS      = 10;
	localparam int HDR_BYTES      = 5;
	localparam int FIRST_DATA     = 4;

	localparam logic [7:0] COLON_CHAR = 8'h3A;
	localparam logic [7:0] REC_DATA   = 8'h00;
	localparam logic [7:0] REC_EXT    = 8'h04;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOL  = 1'b1;

	typedef enum logic [3:0] {
		ST_DATA_OK  = 4'd0,
		ST_EXT_ADDR = 4'd1,
		ST_IGNORED  = 4'd2,
		ST_EMPTY    = 4'd3,
		ST_NO_COLON = 4'd4,
		ST_SHORT    = 4'd5,
		ST_LONG     = 4'd6,
		ST_ODD      = 4'd7,
		ST_BAD_HEX  = 4'd8,
		ST_CHECKSUM = 4'd9,
		ST_COUNT    = 4'd10
	} status_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	// Line summary held by the character decoder, read at end of line
	typedef struct packed {
		logic [CHAR_W-1:0] char_count;
		status_t           first_error; // ST_DATA_OK means no fault yet
		logic [7:0]        sum;
		logic [7:0]        count;
		logic [15:0]       offset;
		logic [7:0]        rec_type;
		logic [7:0]        ext_hi;
		logic [7:0]        ext_lo;
	} line_info_t;

	typedef struct packed {
		logic        is_status;
		logic [31:0] write_address;
		logic [7:0]  write_byte;
		status_t     status;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/intel_hex_record_parser_core.sv -----
`default_nettype none

// Intel HEX record parser. Feed one beat per character (tuser = 0, tdata =
// character) and close each line with an end-of-line beat (tuser = 1, tdata
// ignored). At end of line the record is checked for: empty line, missing
// colon, too short, too long (over 74 characters after the colon), odd
// length, non-hex digits, bad checksum and, for data records, a count that
// exceeds the bytes present. A valid data record emits one write beat per
// data byte to (upper << 16) + offset + index; a type 4 record loads the
// upper address; other types are ignored. Every line ends with a single
// status beat with tuser and tlast set. After an end-of-line beat, each data
// byte takes a line memory read, then a write beat, and the status beat
// follows; the output can stall any of these beats. No input is taken
// while a line's results are being produced. Decoded bytes sit in a small
// line memory with a registered read port.
module intel_hex_record_parser_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,  // [7:0] ch
	input  wire         s_axis_tuser,  // [0] kind
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [31:0] write_address, [39:32] write_byte,
	                                   // [43:40] status, [47:44] zero
	output logic        m_axis_tuser,  // [0] is_status
	output logic        m_axis_tlast   // last
);
	import ihex_pkg::*;

	logic              take;
	logic              eol;
	logic              busy;
	ram_wr_t           wr;
	line_info_t        sum;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic              res_valid;
	result_t           res;
	logic              out_free;
	logic              m_valid_q;
	result_t           m_res_q;

	// Hold off input while a line's results drain
	assign s_axis_tready = !busy;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign eol           = take && (s_axis_tuser == KIND_EOL);

	ihex_char_decoder u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.kind   (s_axis_tuser),
		.ch     (s_axis_tdata),
		.wr     (wr),
		.sum    (sum)
	);

	ihex_line_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ihex_emitter u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.eol       (eol),
		.sum       (sum),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.busy      (busy)
	);

	// Output register: free when empty or being taken this cycle
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'h0, m_res_q.status, m_res_q.write_byte, m_res_q.write_address};
	assign m_axis_tuser  = m_res_q.is_status;
	assign m_axis_tlast  = m_res_q.last;

	a_busy_after_eol: assert property (@(posedge clk) disable iff (!arst_n)
		eol |=> !s_axis_tready)
		else $error("input still open after end of line");

	a_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> !m_axis_tlast)
		else $error("write beat marked last");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[39:0] == 40'h0)
		else $error("status beat carries write payload");

endmodule

`default_nettype wire

// ----- sv/ihex_line_ram.sv -----
`default_nettype none

module ihex_line_ram (
	input  wire                          clk,
	input  wire  ihex_pkg::ram_wr_t      wr,
	input  wire                          rd_en,
	input  wire  [ihex_pkg::ADDR_W-1:0]  rd_addr,
	output logic [7:0]                   rd_data
);
	import ihex_pkg::*;

	logic [7:0] mem [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/ihex_char_decoder.sv -----
`default_nettype none

module ihex_char_decoder (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  take,
	input  wire                  kind,
	input  wire  [7:0]           ch,
	output ihex_pkg::ram_wr_t    wr,
	output ihex_pkg::line_info_t sum
);
	import ihex_pkg::*;

	logic [CHAR_W-1:0] cnt_q;
	logic [7:0]        sum_q;
	logic [3:0]        nib_q;
	status_t           err_q;
	logic [7:0]        count_q, off_hi_q, off_lo_q, type_q, ext_hi_q, ext_lo_q;

	logic [CHAR_W-1:0] pos;
	logic [7:0]        bidx;
	logic              hex_ok;
	logic [3:0]        digit;
	logic [7:0]        byte_val;
	logic              is_char;

	always_comb begin
		hex_ok = 1'b1;
		digit  = 4'h0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			digit = 4'(ch - 8'h30);
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			digit = 4'(ch - 8'h57);
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			digit = 4'(ch - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign is_char  = take && (kind == KIND_CHAR);
	assign pos      = cnt_q - CHAR_W'(1);
	assign bidx     = pos[CHAR_W-1:1];
	assign byte_val = {nib_q, digit};

	assign wr.en   = is_char && (cnt_q != '0) && pos[0] && (bidx < 8'(LINE_DEPTH));
	assign wr.addr = bidx[ADDR_W-1:0];
	assign wr.data = byte_val;

	assign sum.char_count  = cnt_q;
	assign sum.first_error = err_q;
	assign sum.sum         = sum_q;
	assign sum.count       = count_q;
	assign sum.offset      = {off_hi_q, off_lo_q};
	assign sum.rec_type    = type_q;
	assign sum.ext_hi      = ext_hi_q;
	assign sum.ext_lo      = ext_lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			nib_q <= '0;
			err_q <= ST_DATA_OK;
		end else if (take && kind == KIND_EOL) begin
			cnt_q <= '0;
			sum_q <= '0;
			nib_q <= '0;
			err_q <= ST_DATA_OK;
		end else if (is_char) begin
			if (cnt_q == '0) begin
				if (ch != COLON_CHAR) begin
					err_q <= ST_NO_COLON;
				end
			end else begin
				if (!hex_ok && err_q == ST_DATA_OK) begin
					err_q <= ST_BAD_HEX;
				end
				if (!pos[0]) begin
					nib_q <= digit;
				end else begin
					sum_q <= sum_q + byte_val;
				end
			end
			if (cnt_q != '1) begin
				cnt_q <= cnt_q + CHAR_W'(1);
			end
		end
	end

	// Keep a copy of the header bytes and the extended address bytes
	always_ff @(posedge clk) begin
		if (is_char && cnt_q != '0 && pos[0]) begin
			case (bidx)
				8'd0:    count_q  <= byte_val;
				8'd1:    off_hi_q <= byte_val;
				8'd2:    off_lo_q <= byte_val;
				8'd3:    type_q   <= byte_val;
				8'd4:    ext_hi_q <= byte_val;
				8'd5:    ext_lo_q <= byte_val;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/ihex_emitter.sv -----
`default_nettype none

module ihex_emitter (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          eol,
	input  wire  ihex_pkg::line_info_t   sum,
	output logic                         rd_en,
	output logic [ihex_pkg::ADDR_W-1:0]  rd_addr,
	input  wire  [7:0]                   rd_data,
	input  wire                          out_free,
	output logic                         res_valid,
	output ihex_pkg::result_t            res,
	output logic                         busy
);
	import ihex_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_READ   = 4'b0010,
		S_WRITE  = 4'b0100,
		S_STATUS = 4'b1000
	} emit_state_t;

	emit_state_t       state_q;
	status_t           status_q;
	logic [15:0]       upper_q;
	logic [31:0]       base_q;
	logic [IDX_W-1:0]  idx_q, count_q;

	logic [CHAR_W-1:0] len;
	logic [7:0]        nbytes;
	status_t           line_st;

	assign len    = sum.char_count - CHAR_W'(1);
	assign nbytes = len[CHAR_W-1:1];

	// Line checks in priority order
	always_comb begin
		if (sum.char_count == '0) begin
			line_st = ST_EMPTY;
		end else if (sum.first_error == ST_NO_COLON) begin
			line_st = ST_NO_COLON;
		end else if (len < CHAR_W'(MIN_CHARS)) begin
			line_st = ST_SHORT;
		end else if (len > CHAR_W'(LIMIT_CHARS)) begin
			line_st = ST_LONG;
		end else if (len[0]) begin
			line_st = ST_ODD;
		end else if (sum.first_error == ST_BAD_HEX) begin
			line_st = ST_BAD_HEX;
		end else if (sum.sum != 8'h00) begin
			line_st = ST_CHECKSUM;
		end else if (sum.rec_type == REC_DATA) begin
			line_st = (sum.count > nbytes - 8'(HDR_BYTES)) ? ST_COUNT : ST_DATA_OK;
		end else if (sum.rec_type == REC_EXT) begin
			line_st = ST_EXT_ADDR;
		end else begin
			line_st = ST_IGNORED;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign rd_en     = (state_q == S_READ);
	assign rd_addr   = ADDR_W'(FIRST_DATA) + ADDR_W'(idx_q);
	assign res_valid = (state_q == S_WRITE) || (state_q == S_STATUS);

	always_comb begin
		res = '0;
		if (state_q == S_STATUS) begin
			res.is_status = 1'b1;
			res.status    = status_q;
			res.last      = 1'b1;
		end else begin
			res.is_status     = 1'b0;
			res.write_address = base_q + 32'(idx_q);
			res.write_byte    = rd_data;
			res.status        = ST_DATA_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			upper_q <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (eol) begin
						idx_q <= '0;
						if (line_st == ST_EXT_ADDR) begin
							upper_q <= (nbytes >= 8'(HDR_BYTES + 1)) ?
								{sum.ext_hi, sum.ext_lo} : {8'h00, sum.ext_hi};
						end
						if (line_st == ST_DATA_OK && sum.count != 8'h00) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_STATUS;
						end
					end
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (out_free) begin
						idx_q <= idx_q + IDX_W'(1);
						state_q <= (idx_q + IDX_W'(1) == count_q) ? S_STATUS : S_READ;
					end
				end
				S_STATUS: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Latch line results at end of line
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && eol) begin
			status_q <= line_st;
			count_q  <= IDX_W'(sum.count);
			base_q   <= {upper_q, 16'h0000} + {16'h0000, sum.offset};
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |-> idx_q < count_q)
		else $error("write index beyond byte count");

	a_read_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> state_q == S_WRITE)
		else $error("memory read not followed by write beat");

	a_read_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_addr < ADDR_W'(LINE_DEPTH))
		else $error("line memory read out of range");

	a_eol_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		eol |-> state_q == S_IDLE)
		else $error("end of line taken while emitting");

endmodule

`default_nettype wire

// ----- tb/intel_hex_record_parser_core_tb.sv -----
`default_nettype none

module intel_hex_record_parser_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ihex_pkg::*;

	// Cycles with no beat on either side before the run is called hung.
	// The slowest drain is a 32-byte record under full output stalls.
	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_LINES = 4;
	localparam int B2B_LINES = 3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] ch
	logic        s_axis_tuser = 1'b0;   // [0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;          // [31:0] write_address, [39:32] write_byte,
	                                    // [43:40] status, [47:44] zero
	logic        m_axis_tuser;          // [0] is_status
	logic        m_axis_tlast;          // last

	intel_hex_record_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Line decoder mirror: the state the parser keeps while a line
	// arrives, and the results that each line should produce.
	// ---------------------------------------------------------------
	logic [7:0] line_mem [LINE_DEPTH];
	logic [8:0] line_chars = '0;    // saturates at 511
	logic [7:0] line_total = '0;
	logic [3:0] pend_nibble = '0;
	status_t    line_fault = ST_DATA_OK;
	logic [15:0] upper_addr = '0;

	result_t    pending_results[$];

	// Bookkeeping for the run.
	int         faults = 0;
	int         chars_sent = 0;
	int         lines_sent = 0;
	int         writes_seen = 0;
	int         status_seen_cnt = 0;
	logic [15:0] status_seen = '0;
	bit         idle_on = 1'b1;
	int         quiet_cycles = 0;
	int         stall_left = 0;

	// Record under construction: raw bytes, then the text that goes out.
	logic [7:0] rec[$];
	logic [7:0] line_text[$];

	// Value of a hex digit; bit 4 flags a character that is not one.
	function automatic logic [4:0] nibble_of(logic [7:0] c);
		logic [7:0] d;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b0, d[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b0, d[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b0, d[3:0]};
		end
		return 5'h10;
	endfunction

	// Fold one text character into the line state.
	function automatic void decode_char(logic [7:0] c);
		logic [4:0] v;
		int         pos;
		logic [7:0] b;
		if (line_chars == 0) begin
			if (c != COLON_CHAR)
				line_fault = ST_NO_COLON;
		end else begin
			pos = line_chars - 1;
			v = nibble_of(c);
			// a stray character counts as zero but marks the line
			if (v[4]) begin
				if (line_fault == ST_DATA_OK)
					line_fault = ST_BAD_HEX;
				v = 5'h00;
			end
			if (pos % 2 == 0) begin
				pend_nibble = v[3:0];
			end else begin
				b = {pend_nibble, v[3:0]};
				if (pos / 2 < LINE_DEPTH)
					line_mem[pos / 2] = b;
				line_total = line_total + b;
			end
		end
		if (line_chars != 9'd511)
			line_chars = line_chars + 9'd1;
	endfunction

	// Close the line: queue the writes it causes, then its status beat.
	function automatic void finish_line();
		int          len;
		int          nbytes;
		int          i;
		logic [7:0]  cnt;
		logic [7:0]  rtype;
		logic [15:0] offs;
		logic [31:0] base;
		status_t     st;
		result_t     r;
		if (line_chars == 0) begin
			st = ST_EMPTY;
		end else if (line_fault == ST_NO_COLON) begin
			st = ST_NO_COLON;
		end else begin
			len = line_chars - 1;
			if (len < MIN_CHARS)
				st = ST_SHORT;
			else if (len > LIMIT_CHARS)
				st = ST_LONG;
			else if (len % 2 != 0)
				st = ST_ODD;
			else if (line_fault == ST_BAD_HEX)
				st = ST_BAD_HEX;
			else if (line_total != 8'h00)
				st = ST_CHECKSUM;
			else begin
				nbytes = len / 2;
				cnt    = line_mem[0];
				offs   = {line_mem[1], line_mem[2]};
				rtype  = line_mem[3];
				if (rtype == REC_DATA) begin
					if (cnt > nbytes - HDR_BYTES) begin
						st = ST_COUNT;
					end else begin
						// address wraps at 32 bits
						base = {upper_addr, 16'h0000} + {16'h0000, offs};
						for (i = 0; i < cnt; i++) begin
							r.is_status     = 1'b0;
							r.write_address = base + i;
							r.write_byte    = line_mem[FIRST_DATA + i];
							r.status        = ST_DATA_OK;
							r.last          = 1'b0;
							pending_results = {pending_results, r};
						end
						st = ST_DATA_OK;
					end
				end else if (rtype == REC_EXT) begin
					// a five-byte record takes the checksum byte as the address
					if (nbytes >= HDR_BYTES + 1)
						upper_addr = {line_mem[FIRST_DATA], line_mem[FIRST_DATA + 1]};
					else
						upper_addr = {8'h00, line_mem[FIRST_DATA]};
					st = ST_EXT_ADDR;
				end else begin
					st = ST_IGNORED;
				end
			end
		end
		r.is_status     = 1'b1;
		r.write_address = '0;
		r.write_byte    = '0;
		r.status        = st;
		r.last          = 1'b1;
		pending_results = {pending_results, r};
		line_chars  = '0;
		line_total  = '0;
		pend_nibble = '0;
		line_fault  = ST_DATA_OK;
	endfunction

	// ---------------------------------------------------------------
	// Record text builders
	// ---------------------------------------------------------------
	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + v;
		if ($urandom_range(0, 1) != 0)
			return 8'h37 + v;   // upper case
		return 8'h57 + v;       // lower case
	endfunction

	function automatic logic [7:0] non_colon();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == COLON_CHAR);
		return c;
	endfunction

	// Header plus ndata random payload bytes; the count field is free.
	task automatic start_record(input logic [7:0] cnt, input logic [15:0] offs,
	                            input logic [7:0] rtype, input int ndata);
		rec = {};
		rec = {rec, cnt};
		rec = {rec, offs[15:8]};
		rec = {rec, offs[7:0]};
		rec = {rec, rtype};
		repeat (ndata) rec = {rec, 8'($urandom_range(0, 255))};
	endtask

	task automatic encode_text();
		line_text = {};
		line_text = {line_text, COLON_CHAR};
		foreach (rec[i]) begin
			line_text = {line_text, hex_char(rec[i][7:4])};
			line_text = {line_text, hex_char(rec[i][3:0])};
		end
	endtask

	// Append the checksum that brings the byte sum to zero, then encode.
	task automatic seal_record();
		logic [7:0] s;
		s = 8'h00;
		foreach (rec[i]) s = s + rec[i];
		s = 8'h00 - s;
		rec = {rec, s};
		encode_text();
	endtask

	// ---------------------------------------------------------------
	// Stimulus side
	// ---------------------------------------------------------------

	// Present one beat and hold it until taken; fold it into the mirror.
	task automatic send_beat(input logic kind, input logic [7:0] ch);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= ch;
		do @(posedge clk); while (!s_axis_tready);
		if (kind == KIND_CHAR) begin
			decode_char(ch);
			chars_sent++;
		end else begin
			finish_line();
		end
	endtask

	task automatic send_line();
		foreach (line_text[i]) send_beat(KIND_CHAR, line_text[i]);
		send_beat(KIND_EOL, 8'($urandom_range(0, 255)));
		lines_sent++;
	endtask

	task automatic send_record(input logic [7:0] cnt, input logic [15:0] offs,
	                           input logic [7:0] rtype, input int ndata);
		start_record(cnt, offs, rtype, ndata);
		seal_record();
		send_line();
	endtask

	// Hold the input idle until every queued result has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_format_faults();
		int pos;
		// empty line
		line_text = {};
		send_line();
		// missing colon
		start_record(8'd0, 16'($urandom), REC_DATA, 0);
		seal_record();
		line_text[0] = non_colon();
		send_line();
		// colon alone, and nine characters after it
		line_text = {COLON_CHAR};
		send_line();
		start_record(8'd0, 16'h0000, REC_DATA, 0);
		seal_record();
		void'(line_text.pop_back());
		send_line();
		// odd length
		start_record(8'd1, 16'($urandom), REC_DATA, 1);
		seal_record();
		void'(line_text.pop_back());
		send_line();
		// one byte past the line store
		start_record(8'd33, 16'($urandom), REC_DATA, 33);
		seal_record();
		send_line();
		// stray letter or a second colon inside the line
		start_record(8'd0, 16'($urandom), REC_DATA, 0);
		seal_record();
		pos = $urandom_range(1, line_text.size() - 1);
		line_text[pos] = ($urandom_range(0, 1) != 0) ? COLON_CHAR : 8'h47;
		send_line();
		// bad checksum
		start_record(8'd0, 16'($urandom), REC_DATA, 0);
		seal_record();
		rec[rec.size() - 1] = rec[rec.size() - 1] + 8'h01;
		encode_text();
		send_line();
	endtask

	task automatic test_data_records();
		send_record(8'd0, 16'($urandom), REC_DATA, 0);
		send_record(8'(MAX_DATA_BYTES), 16'hFFFF, REC_DATA, MAX_DATA_BYTES);
		// count beyond the bytes present
		send_record(8'd2, 16'($urandom), REC_DATA, 1);
		// spare bytes beyond the count are dropped
		send_record(8'd1, 16'($urandom), REC_DATA, 3);
	endtask

	task automatic test_extended_address();
		start_record(8'd2, 16'h0000, REC_EXT, 2);
		rec[4] = 8'h12;
		rec[5] = 8'h34;
		seal_record();
		send_line();
		send_record(8'd1, 16'($urandom), REC_DATA, 1);
		// short type 4: the checksum byte becomes the upper address
		send_record(8'd0, 16'($urandom), REC_EXT, 0);
		send_record(8'd1, 16'($urandom), REC_DATA, 1);
		// top of the address space, so the writes wrap to zero
		start_record(8'd2, 16'h0000, REC_EXT, 2);
		rec[4] = 8'hFF;
		rec[5] = 8'hFF;
		seal_record();
		send_line();
		send_record(8'd4, 16'hFFFE, REC_DATA, 4);
		drain_results();
	endtask

	task automatic test_ignored_types();
		logic [7:0] types[3];
		int n;
		types = '{8'h01, 8'h05, 8'hFF};
		foreach (types[i]) begin
			n = $urandom_range(0, 1);
			send_record(8'(n), 16'($urandom), types[i], n);
		end
	endtask

	// One random line: mostly well-formed records with random content,
	// the rest broken in one of several ways.
	task automatic random_line();
		int         pick;
		int         n;
		int         extra;
		int         pos;
		logic [7:0] rtype;
		pick  = $urandom_range(0, 99);
		n     = ($urandom_range(0, 15) == 0) ? $urandom_range(0, MAX_DATA_BYTES) :
		        $urandom_range(0, 6);
		extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		if (n + extra > MAX_DATA_BYTES)
			extra = MAX_DATA_BYTES - n;
		if (pick < 45) begin
			send_record(8'(n), 16'($urandom), REC_DATA, n + extra);
		end else if (pick < 55) begin
			if ($urandom_range(0, 4) == 0)
				send_record(8'($urandom), 16'($urandom), REC_EXT, 0);
			else
				send_record(8'd2, 16'($urandom), REC_EXT, 2 + $urandom_range(0, 2));
		end else if (pick < 62) begin
			do rtype = 8'($urandom_range(1, 255)); while (rtype == REC_EXT);
			send_record(8'(n), 16'($urandom), rtype, n);
		end else begin
			n = $urandom_range(1, 6);
			start_record(8'(n), 16'($urandom), REC_DATA, n);
			seal_record();
			case ($urandom_range(0, 9))
				0: begin
					// any byte value anywhere in the line
					pos = $urandom_range(0, line_text.size() - 1);
					line_text[pos] = 8'($urandom_range(0, 255));
				end
				1: begin
					rec[rec.size() - 1] = rec[rec.size() - 1] ^ (8'h01 << $urandom_range(0, 7));
					encode_text();
				end
				2: line_text.delete($urandom_range(1, line_text.size() - 1));
				3: begin
					pos = $urandom_range(1, line_text.size());
					line_text.insert(pos, hex_char(4'($urandom)));
				end
				4: begin
					start_record(8'(n + $urandom_range(1, 3)), 16'($urandom), REC_DATA, n);
					seal_record();
				end
				5: line_text[0] = non_colon();
				6: begin
					pos = $urandom_range(1, 10);
					while (line_text.size() > pos) void'(line_text.pop_back());
				end
				7: begin
					line_text = {};
					repeat ($urandom_range(1, 16))
						line_text = {line_text, 8'($urandom_range(0, 255))};
					if ($urandom_range(0, 1) != 0)
						line_text[0] = COLON_CHAR;
				end
				8: line_text = {};
				default: begin
					start_record(8'd33, 16'($urandom), REC_DATA, 33 + $urandom_range(0, 2));
					seal_record();
				end
			endcase
			send_line();
		end
	endtask

	task automatic test_random_records();
		int count;
		for (count = 1; count <= RANDOM_LINES; count++) begin
			// leave some lines without any idling
			idle_on = ($urandom_range(0, 3) != 0);
			random_line();
			if (count % 2 == 0)
				drain_results();
		end
		idle_on = 1'b1;
	endtask

	// Last stretch: both sides run flat out.
	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (B2B_LINES) random_line();
	endtask

	// ---------------------------------------------------------------
	// Output side: random back-pressure in bursts of stalled cycles
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && arst_n && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare every output beat against the oldest expectation.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: tdata %h tuser %b tlast %b",
				       m_axis_tdata, m_axis_tuser, m_axis_tlast);
				faults++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.is_status) begin
					$error("is_status: expected %b, got %b", want.is_status, m_axis_tuser);
					faults++;
				end
				if (m_axis_tdata[31:0] !== want.write_address) begin
					$error("write_address: expected %h, got %h",
					       want.write_address, m_axis_tdata[31:0]);
					faults++;
				end
				if (m_axis_tdata[39:32] !== want.write_byte) begin
					$error("write_byte: expected %h, got %h", want.write_byte,
					       m_axis_tdata[39:32]);
					faults++;
				end
				if (m_axis_tdata[43:40] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tdata[43:40]);
					faults++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last: expected %b, got %b", want.last, m_axis_tlast);
					faults++;
				end
				if (want.is_status) begin
					status_seen[want.status] = 1'b1;
					status_seen_cnt++;
				end else begin
					writes_seen++;
				end
			end
		end
	end

	// Hang detector: count cycles in which neither side moves a beat.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d results outstanding",
			         quiet_cycles, pending_results.size());
			$display("intel_hex_record_parser_core_tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_format_faults();
		test_data_records();
		test_extended_address();
		test_ignored_types();
		test_random_records();
		test_back_to_back();

		// stop sending, let the last line drain, then watch for strays
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			faults++;
		end

		$display("sent %0d lines (%0d characters); checked %0d byte writes, %0d status beats",
		         lines_sent, chars_sent, writes_seen, status_seen_cnt);
		$display("status codes observed (bit per code): %b", status_seen[10:0]);
		if (faults == 0)
			$display("intel_hex_record_parser_core_tb: clean");
		else
			$display("intel_hex_record_parser_core_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire

// ----- intel_hex_record_parser_core.f -----
sv/ihex_pkg.sv
sv/ihex_line_ram.sv
sv/ihex_char_decoder.sv
sv/ihex_emitter.sv
sv/intel_hex_record_parser_core.sv
tb/intel_hex_record_parser_core_tb.sv
